/* hw/rtl/trspd_pkg.sv */
`timescale 1ns / 1ps

package trspd_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 64;

   // register map
   localparam logic REG_MAX_ITER = 1'b0;
   localparam logic REG_THRESH   = 1'b1;
   localparam logic [7:0]  MAX_ITER_RST = 8'd100;
   localparam logic [15:0] THRESH_RST   = 16'd7;

   // scratch store layout
   localparam int A_M     = 0;
   localparam int A_T     = 9;
   localparam int A_ZERO  = 12;
   localparam int A_R     = 13;
   localparam int A_COF   = 22;
   localparam int A_DET   = 31;
   localparam int A_P1    = 32;
   localparam int A_P2    = 33;
   localparam int A_NR    = 34;
   localparam int A_S     = 43;
   localparam int A_U     = 44;
   localparam int RAM_DEPTH = 45;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int LOAD_LAST = A_ZERO;

   typedef enum logic [3:0] {
      OP_MUL,
      OP_DIV,
      OP_ADD,
      OP_SUB,
      OP_AVG,
      OP_DIFF,
      OP_MOV,
      OP_OUT,
      OP_TEST,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type            kind;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] d;
   } uop_type;

   typedef struct packed {
      logic start;
      logic op_div;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] value;
   } md_rsp_type;

   localparam int PROG_LEN = 136;
   localparam int PC_W     = $clog2(PROG_LEN);
   localparam int ITER_PC  = 9;

   typedef uop_type [PROG_LEN-1:0] prog_type;

   function automatic uop_type mk(op_type k, int a, int b, int d);
      uop_type u;
      u.kind = k;
      u.a    = ADDR_W'(a);
      u.b    = ADDR_W'(b);
      u.d    = ADDR_W'(d);
      return u;
   endfunction

   function automatic prog_type build_prog();
      prog_type p;
      int n, i, j, i1, i2, j1, j2;
      p = '0;
      n = 0;
      for (i = 0; i < 9; i++) begin
         p[n] = mk(OP_MOV, A_M + i, A_M, A_R + i); n = n + 1;
      end
      // cofactors
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            i1 = (i + 1) % 3; i2 = (i + 2) % 3;
            j1 = (j + 1) % 3; j2 = (j + 2) % 3;
            p[n] = mk(OP_MUL, A_R + 3*i1 + j1, A_R + 3*i2 + j2, A_P1); n = n + 1;
            p[n] = mk(OP_MUL, A_R + 3*i1 + j2, A_R + 3*i2 + j1, A_P2); n = n + 1;
            p[n] = mk(OP_SUB, A_P1, A_P2, A_COF + 3*i + j); n = n + 1;
         end
      end
      // determinant along row 0
      p[n] = mk(OP_MUL, A_R,     A_COF,     A_DET); n = n + 1;
      p[n] = mk(OP_MUL, A_R + 1, A_COF + 1, A_P1);  n = n + 1;
      p[n] = mk(OP_ADD, A_DET,   A_P1,      A_DET); n = n + 1;
      p[n] = mk(OP_MUL, A_R + 2, A_COF + 2, A_P1);  n = n + 1;
      p[n] = mk(OP_ADD, A_DET,   A_P1,      A_DET); n = n + 1;
      // averaging step and largest change
      for (i = 0; i < 9; i++) begin
         p[n] = mk(OP_DIV,  A_COF + i, A_DET,    A_P1);     n = n + 1;
         p[n] = mk(OP_AVG,  A_R + i,   A_P1,     A_NR + i); n = n + 1;
         p[n] = mk(OP_DIFF, A_R + i,   A_NR + i, A_P1);     n = n + 1;
      end
      for (i = 0; i < 9; i++) begin
         p[n] = mk(OP_MOV, A_NR + i, A_M, A_R + i); n = n + 1;
      end
      p[n] = mk(OP_TEST, A_M, A_M, A_M); n = n + 1;
      // scales, translation terms and the inverse
      for (i = 0; i < 3; i++) begin
         p[n] = mk(OP_MUL, A_R + i,     A_M + i,     A_S);  n = n + 1;
         p[n] = mk(OP_MUL, A_R + 3 + i, A_M + 3 + i, A_P1); n = n + 1;
         p[n] = mk(OP_ADD, A_S,         A_P1,        A_S);  n = n + 1;
         p[n] = mk(OP_MUL, A_R + 6 + i, A_M + 6 + i, A_P1); n = n + 1;
         p[n] = mk(OP_ADD, A_S,         A_P1,        A_S);  n = n + 1;
         p[n] = mk(OP_MUL, A_R + i,     A_T,         A_U);  n = n + 1;
         p[n] = mk(OP_MUL, A_R + 3 + i, A_T + 1,     A_P1); n = n + 1;
         p[n] = mk(OP_ADD, A_U,         A_P1,        A_U);  n = n + 1;
         p[n] = mk(OP_MUL, A_R + 6 + i, A_T + 2,     A_P1); n = n + 1;
         p[n] = mk(OP_ADD, A_U,         A_P1,        A_U);  n = n + 1;
         for (j = 0; j < 3; j++) begin
            p[n] = mk(OP_DIV, A_R + 3*j + i, A_S, A_P1); n = n + 1;
            p[n] = mk(OP_OUT, A_P1, A_M, 3*i + j);       n = n + 1;
         end
         p[n] = mk(OP_DIV, A_U,    A_S,  A_P1); n = n + 1;
         p[n] = mk(OP_SUB, A_ZERO, A_P1, A_P1); n = n + 1;
         p[n] = mk(OP_OUT, A_P1,   A_M,  9 + i); n = n + 1;
      end
      p[n] = mk(OP_DONE, A_M, A_M, A_M);
      return p;
   endfunction

   localparam prog_type PROG = build_prog();

endpackage

/* hw/rtl/trs_polar_decomposition_inverse_core.sv */
`timescale 1ns / 1ps

// Channel   | Ports                                | Handshake
// ----------+--------------------------------------+-------------------------------------
// request   | req_rs_00..req_rs_22, req_shift_x/y/z | taken when start is high, busy low
// result    | rsp_inv_00..rsp_inv_22, rsp_inv_shift | rsp_valid high for one cycle
// config    | psel penable pwrite paddr pwdata ...  | APB write, pready tied high
//
// One request at a time; busy stays high from acceptance until the result strobe.
// Each request runs a load of the store, a copy, the polar steps, then the scales,
// inverse and finish. Multiplies and divides go to the shared multiply/divide unit,
// which returns early when an operand is zero.
// Reset is synchronous and restores max_iterations = 100, threshold = 7.
// The receiver cannot stall: the result is shown once, for one cycle.

module trs_polar_decomposition_inverse_core #(
   parameter int FRAC_BITS = trspd_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_rs_00,
   input  logic signed [31:0] req_rs_01,
   input  logic signed [31:0] req_rs_02,
   input  logic signed [31:0] req_rs_10,
   input  logic signed [31:0] req_rs_11,
   input  logic signed [31:0] req_rs_12,
   input  logic signed [31:0] req_rs_20,
   input  logic signed [31:0] req_rs_21,
   input  logic signed [31:0] req_rs_22,
   input  logic signed [47:0] req_shift_x,
   input  logic signed [47:0] req_shift_y,
   input  logic signed [47:0] req_shift_z,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_inv_00,
   output logic signed [31:0] rsp_inv_01,
   output logic signed [31:0] rsp_inv_02,
   output logic signed [31:0] rsp_inv_10,
   output logic signed [31:0] rsp_inv_11,
   output logic signed [31:0] rsp_inv_12,
   output logic signed [31:0] rsp_inv_20,
   output logic signed [31:0] rsp_inv_21,
   output logic signed [31:0] rsp_inv_22,
   output logic signed [47:0] rsp_inv_shift_x,
   output logic signed [47:0] rsp_inv_shift_y,
   output logic signed [47:0] rsp_inv_shift_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = trspd_pkg::ADDR_W;
   localparam int PW = trspd_pkg::PC_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOAD  = 5'b00010,
      S_FETCH = 5'b00100,
      S_EXEC  = 5'b01000,
      S_WAIT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [PW-1:0]      pc_ff, pc_in;
   logic [3:0]         ld_cnt_ff, ld_cnt_in;
   logic [7:0]         count_ff, count_in;
   logic [63:0]        worst_ff, worst_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         max_iter_ff, max_iter_in;
   logic [15:0]        thresh_ff, thresh_in;
   logic [63:0]        stage_ff [13];
   logic [63:0]        stage_in [13];
   logic signed [31:0] inv_ff [9];
   logic signed [31:0] inv_in [9];
   logic signed [47:0] ish_ff [3];
   logic signed [47:0] ish_in [3];

   trspd_pkg::uop_type    cur;
   trspd_pkg::md_req_type md_req;
   trspd_pkg::md_rsp_type md_rsp;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [63:0]   ram_wdata;
   logic [63:0]   rd_a, rd_b;

   logic [63:0] sum_sat, dif_sat, avg, dif_mag;
   logic        keep_going;
   logic        cfg_wr;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic [31:0] clamp32(input logic [63:0] x);
      if (x[63:31] == '0 || x[63:31] == '1) begin
         return x[31:0];
      end
      return x[63] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
   endfunction

   function automatic logic [47:0] clamp48(input logic [63:0] x);
      if (x[63:47] == '0 || x[63:47] == '1) begin
         return x[47:0];
      end
      return x[63] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
   endfunction

   // micro-op of the current step
   assign cur = trspd_pkg::PROG[pc_ff];

   // simple ALU on the two operands read from the scratch store
   assign sum_sat = sat_add(rd_a, rd_b);
   assign dif_sat = sat_sub(rd_a, rd_b);
   assign avg     = {sum_sat[63], sum_sat[63:1]};
   assign dif_mag = dif_sat[63] ? (~dif_sat + 64'd1) : dif_sat;

   // iterate again while under the limit and the change is still too large
   assign keep_going = (({1'b0, count_ff} + 9'd1) < {1'b0, max_iter_ff}) &&
                       (worst_ff > 64'(thresh_ff));

   trspd_ram #(
      .WIDTH (64),
      .DEPTH (trspd_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (cur.a),
      .raddr_b (cur.b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   trspd_muldiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .op_a  (rd_a),
      .op_b  (rd_b),
      .rsp   (md_rsp)
   );

   // scratch store write port: load sweep, ALU results, unit results
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cur.d;
      ram_wdata = rd_a;
      if (state_ff == S_LOAD) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(ld_cnt_ff);
         ram_wdata = stage_ff[0];
      end else if (state_ff == S_EXEC) begin
         unique case (cur.kind)
            trspd_pkg::OP_ADD: begin ram_we = 1'b1; ram_wdata = sum_sat; end
            trspd_pkg::OP_SUB: begin ram_we = 1'b1; ram_wdata = dif_sat; end
            trspd_pkg::OP_AVG: begin ram_we = 1'b1; ram_wdata = avg;     end
            trspd_pkg::OP_MOV: begin ram_we = 1'b1; ram_wdata = rd_a;    end
            default:           ram_we = 1'b0;
         endcase
      end else if (state_ff == S_WAIT && md_rsp.done) begin
         ram_we    = 1'b1;
         ram_wdata = md_rsp.value;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ld_cnt_in    = ld_cnt_ff;
      count_in     = count_ff;
      worst_in     = worst_ff;
      rsp_valid_in = 1'b0;
      stage_in     = stage_ff;
      inv_in       = inv_ff;
      ish_in       = ish_ff;
      md_req       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // hold the request, sign-extended to working width
               stage_in[0]  = 64'(req_rs_00);
               stage_in[1]  = 64'(req_rs_01);
               stage_in[2]  = 64'(req_rs_02);
               stage_in[3]  = 64'(req_rs_10);
               stage_in[4]  = 64'(req_rs_11);
               stage_in[5]  = 64'(req_rs_12);
               stage_in[6]  = 64'(req_rs_20);
               stage_in[7]  = 64'(req_rs_21);
               stage_in[8]  = 64'(req_rs_22);
               stage_in[9]  = 64'(req_shift_x);
               stage_in[10] = 64'(req_shift_y);
               stage_in[11] = 64'(req_shift_z);
               stage_in[12] = '0;
               ld_cnt_in    = '0;
               state_in     = S_LOAD;
            end
         end
         S_LOAD: begin
            // shift the held request into the store, one word a cycle
            for (int k = 0; k < 12; k++) begin
               stage_in[k] = stage_ff[k+1];
            end
            stage_in[12] = '0;
            ld_cnt_in    = ld_cnt_ff + 4'd1;
            if (ld_cnt_ff == 4'(trspd_pkg::LOAD_LAST)) begin
               pc_in    = '0;
               count_in = '0;
               worst_in = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (cur.kind)
               trspd_pkg::OP_MUL, trspd_pkg::OP_DIV: begin
                  md_req.start  = 1'b1;
                  md_req.op_div = (cur.kind == trspd_pkg::OP_DIV);
                  state_in      = S_WAIT;
               end
               trspd_pkg::OP_DIFF: begin
                  if (dif_mag > worst_ff) begin
                     worst_in = dif_mag;
                  end
                  pc_in    = pc_ff + PW'(1);
                  state_in = S_FETCH;
               end
               trspd_pkg::OP_OUT: begin
                  for (int k = 0; k < 9; k++) begin
                     if (cur.d == AW'(k)) begin
                        inv_in[k] = clamp32(rd_a);
                     end
                  end
                  for (int k = 0; k < 3; k++) begin
                     if (cur.d == AW'(9 + k)) begin
                        ish_in[k] = clamp48(rd_a);
                     end
                  end
                  pc_in    = pc_ff + PW'(1);
                  state_in = S_FETCH;
               end
               trspd_pkg::OP_TEST: begin
                  if (keep_going) begin
                     pc_in    = PW'(trspd_pkg::ITER_PC);
                     count_in = count_ff + 8'd1;
                     worst_in = '0;
                  end else begin
                     pc_in = pc_ff + PW'(1);
                  end
                  state_in = S_FETCH;
               end
               trspd_pkg::OP_DONE: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               trspd_pkg::OP_ADD, trspd_pkg::OP_SUB,
               trspd_pkg::OP_AVG, trspd_pkg::OP_MOV: begin
                  pc_in    = pc_ff + PW'(1);
                  state_in = S_FETCH;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_WAIT: begin
            // advance once the shared unit hands back its result
            if (md_rsp.done) begin
               pc_in    = pc_ff + PW'(1);
               state_in = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      max_iter_in = max_iter_ff;
      thresh_in   = thresh_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            trspd_pkg::REG_MAX_ITER: max_iter_in = pwdata[7:0];
            trspd_pkg::REG_THRESH:   thresh_in   = pwdata[15:0];
            default:                 max_iter_in = max_iter_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == trspd_pkg::REG_THRESH) ? 32'(thresh_ff) : 32'(max_iter_ff);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= trspd_pkg::MAX_ITER_RST;
         thresh_ff    <= trspd_pkg::THRESH_RST;
         pc_ff        <= '0;
         ld_cnt_ff    <= '0;
         count_ff     <= '0;
         worst_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_iter_ff  <= max_iter_in;
         thresh_ff    <= thresh_in;
         pc_ff        <= pc_in;
         ld_cnt_ff    <= ld_cnt_in;
         count_ff     <= count_in;
         worst_ff     <= worst_in;
      end
      stage_ff <= stage_in;
      inv_ff   <= inv_in;
      ish_ff   <= ish_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inv_00      = inv_ff[0];
   assign rsp_inv_01      = inv_ff[1];
   assign rsp_inv_02      = inv_ff[2];
   assign rsp_inv_10      = inv_ff[3];
   assign rsp_inv_11      = inv_ff[4];
   assign rsp_inv_12      = inv_ff[5];
   assign rsp_inv_20      = inv_ff[6];
   assign rsp_inv_21      = inv_ff[7];
   assign rsp_inv_22      = inv_ff[8];
   assign rsp_inv_shift_x = ish_ff[0];
   assign rsp_inv_shift_y = ish_ff[1];
   assign rsp_inv_shift_z = ish_ff[2];

endmodule

/* hw/rtl/trspd_ram.sv */
`timescale 1ns / 1ps

module trspd_ram #(
   parameter int WIDTH = trspd_pkg::WORD_W,
   parameter int DEPTH = trspd_pkg::RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

/* hw/rtl/trspd_muldiv.sv */
`timescale 1ns / 1ps

module trspd_muldiv #(
   parameter int FRAC_BITS = trspd_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trspd_pkg::md_req_type   req,
   input  logic [63:0]             op_a,
   input  logic [63:0]             op_b,
   output trspd_pkg::md_rsp_type   rsp
);

   localparam int DVD_W = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] NEG_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_MUL  = 4'b0010,
      M_DIV  = 4'b0100,
      M_FIN  = 4'b1000
   } md_state_type;

   md_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [63:0]       ua_ff, ua_in, ub_ff, ub_in;
   logic              neg_ff, neg_in, div_ff, div_in;
   logic [127:0]      acc_ff, acc_in;
   logic [63:0]       pp_ff, pp_in;
   logic [1:0]        sh_ff, sh_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [63:0]       rem_ff, rem_in;
   logic              done_ff, done_in;
   logic [63:0]       res_ff, res_in;

   logic [63:0]  mag_a, mag_b;
   logic [64:0]  rem_sh;
   logic [127:0] quo;
   logic [63:0]  lim;
   logic         over;
   logic [127:0] pp_wide;

   assign mag_a   = op_a[63] ? (~op_a + 64'd1) : op_a;
   assign mag_b   = op_b[63] ? (~op_b + 64'd1) : op_b;
   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign quo     = div_ff ? acc_ff : (acc_ff >> FRAC_BITS);
   assign lim     = neg_ff ? NEG_MIN : POS_MAX;
   assign over    = (|quo[127:64]) || (quo[63:0] > lim);
   assign pp_wide = 128'(pp_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               ua_in  = mag_a;
               ub_in  = mag_b;
               neg_in = op_a[63] ^ op_b[63];
               div_in = req.op_div;
               acc_in = '0;
               cnt_in = '0;
               if (mag_a == '0 || (!req.op_div && mag_b == '0)) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else if (mag_b == '0) begin
                  res_in  = (op_a[63] ^ op_b[63]) ? NEG_MIN : POS_MAX;
                  done_in = 1'b1;
               end else if (req.op_div) begin
                  dvd_in   = DVD_W'(mag_a) << FRAC_BITS;
                  rem_in   = '0;
                  cnt_in   = CNT_W'(DVD_W - 1);
                  state_in = M_DIV;
               end else begin
                  state_in = M_MUL;
               end
            end
         end
         M_MUL: begin
            // four 32x32 partial products, each accumulated in the cycle after it is formed
            if (cnt_ff < CNT_W'(4)) begin
               pp_in = (cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0]) *
                       (cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0]);
               sh_in = cnt_ff[1:0];
            end
            if (cnt_ff != '0) begin
               unique case (sh_ff)
                  2'd0:       acc_in = acc_ff + pp_wide;
                  2'd1, 2'd2: acc_in = acc_ff + (pp_wide << 32);
                  2'd3:       acc_in = acc_ff + (pp_wide << 64);
                  default:    acc_in = acc_ff;
               endcase
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(4)) begin
               state_in = M_FIN;
            end
         end
         M_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_sh >= {1'b0, ub_ff}) begin
               rem_in = 64'(rem_sh - {1'b0, ub_ff});
               acc_in = {acc_ff[126:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               acc_in = {acc_ff[126:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            if (over) begin
               res_in = lim;
            end else begin
               res_in = neg_ff ? (~quo[63:0] + 64'd1) : quo[63:0];
            end
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

/* test/trs_polar_decomposition_inverse_core_test.sv */
`timescale 1ns / 1ps

module trs_polar_decomposition_inverse_core_test;

   localparam logic signed [63:0] ONE   = 64'sd1 <<< trspd_pkg::FRAC_BITS_DEF;
   localparam logic signed [31:0] UNIT  = ONE[31:0];
   localparam logic signed [63:0] S64MX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64MN = {1'b1, {63{1'b0}}};
   localparam logic signed [47:0] S48MX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] S48MN = {1'b1, {47{1'b0}}};
   localparam logic [2:0] ADDR_ITER   = 3'(4 * trspd_pkg::REG_MAX_ITER);
   localparam logic [2:0] ADDR_THRESH = 3'(4 * trspd_pkg::REG_THRESH);
   localparam int DIR_ROWS = 22;

   typedef struct {
      logic signed [31:0] rs [9];
      logic signed [47:0] sh [3];
   } transform_type;

   typedef struct {
      logic signed [31:0] inv [9];
      logic signed [47:0] sh [3];
   } inverse_type;

   // one line of the directed table: either a register write or a request
   typedef struct {
      bit            is_cfg;
      logic [7:0]    iter;
      logic [15:0]   thresh;
      transform_type req;
      bit            has_exp;
      inverse_type   exp;
   } dir_row_type;

   logic clock, reset, start, busy, rsp_valid;
   logic psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic signed [31:0] req_rs [9];
   logic signed [47:0] req_sh [3];
   logic signed [31:0] rsp_inv [9];
   logic signed [47:0] rsp_sh [3];

   logic [7:0]  model_iter;
   logic [15:0] model_thresh;
   inverse_type pending_inverses [$];
   int          mismatches;
   dir_row_type dir_table [DIR_ROWS];

   trs_polar_decomposition_inverse_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_rs_00(req_rs[0]), .req_rs_01(req_rs[1]), .req_rs_02(req_rs[2]),
      .req_rs_10(req_rs[3]), .req_rs_11(req_rs[4]), .req_rs_12(req_rs[5]),
      .req_rs_20(req_rs[6]), .req_rs_21(req_rs[7]), .req_rs_22(req_rs[8]),
      .req_shift_x(req_sh[0]), .req_shift_y(req_sh[1]), .req_shift_z(req_sh[2]),
      .rsp_valid(rsp_valid),
      .rsp_inv_00(rsp_inv[0]), .rsp_inv_01(rsp_inv[1]), .rsp_inv_02(rsp_inv[2]),
      .rsp_inv_10(rsp_inv[3]), .rsp_inv_11(rsp_inv[4]), .rsp_inv_12(rsp_inv[5]),
      .rsp_inv_20(rsp_inv[6]), .rsp_inv_21(rsp_inv[7]), .rsp_inv_22(rsp_inv[8]),
      .rsp_inv_shift_x(rsp_sh[0]), .rsp_inv_shift_y(rsp_sh[1]),
      .rsp_inv_shift_z(rsp_sh[2]),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous time-out: report failure if the run never finishes
   initial begin
      #300_000_000;
      $display("trs_polar_decomposition_inverse_core test failed");
      $finish;
   end

   // ---------------------------------------------------------------- arithmetic
   // a*b/c exact in 128 bits, truncated toward zero, saturated to 64 bits
   function automatic logic signed [63:0] mul_div(input logic signed [63:0] a, b, c);
      logic neg;
      logic [63:0] ua, ub, uc;
      logic [127:0] quo;
      neg = a[63] ^ b[63] ^ c[63];
      ua = a[63] ? 64'(-a) : a;
      ub = b[63] ? 64'(-b) : b;
      uc = c[63] ? 64'(-c) : c;
      if (ua == 0 || ub == 0) return 64'sd0;
      if (uc == 0) return neg ? S64MN : S64MX;
      quo = ({64'd0, ua} * {64'd0, ub}) / {64'd0, uc};
      if (neg) begin
         if (quo >= (128'd1 << 63)) return S64MN;
         return -$signed(quo[63:0]);
      end
      if (quo > 128'(S64MX)) return S64MX;
      return $signed(quo[63:0]);
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a, b);
      logic signed [64:0] sum;
      sum = 65'(a) + 65'(b);
      if (sum > 65'(S64MX)) return S64MX;
      if (sum < 65'(S64MN)) return S64MN;
      return sum[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a, b);
      logic signed [64:0] dif;
      dif = 65'(a) - 65'(b);
      if (dif > 65'(S64MX)) return S64MX;
      if (dif < 65'(S64MN)) return S64MN;
      return dif[63:0];
   endfunction

   // polar decomposition followed by the scaled, transposed inverse
   function automatic inverse_type invert_transform(input transform_type tf);
      logic signed [63:0] m [9], r [9], nx [9], cof [9], t [3];
      logic signed [63:0] det, s, u, q;
      logic [63:0] worst, d;
      int count, i, j, k;
      inverse_type res;
      for (i = 0; i < 9; i++) begin
         m[i] = 64'(tf.rs[i]);
         r[i] = m[i];
      end
      for (i = 0; i < 3; i++) t[i] = 64'(tf.sh[i]);
      count = 0;
      do begin
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
               cof[3*i+j] = sat_sub(
                  mul_div(r[3*((i+1)%3)+(j+1)%3], r[3*((i+2)%3)+(j+2)%3], ONE),
                  mul_div(r[3*((i+1)%3)+(j+2)%3], r[3*((i+2)%3)+(j+1)%3], ONE));
         det = 0;
         for (j = 0; j < 3; j++) det = sat_add(det, mul_div(r[j], cof[j], ONE));
         worst = 0;
         for (i = 0; i < 9; i++) begin
            nx[i] = sat_add(r[i], mul_div(cof[i], ONE, det)) >>> 1;
            q = sat_sub(r[i], nx[i]);
            d = q[63] ? 64'(-q) : q;
            if (d > worst) worst = d;
         end
         r = nx;
         count++;
      end while (count < int'(model_iter) && worst > 64'(model_thresh));
      for (i = 0; i < 3; i++) begin
         s = 0;
         u = 0;
         for (k = 0; k < 3; k++) begin
            s = sat_add(s, mul_div(r[3*k+i], m[3*k+i], ONE));
            u = sat_add(u, mul_div(r[3*k+i], t[k], ONE));
         end
         for (j = 0; j < 3; j++) begin
            q = mul_div(r[3*j+i], ONE, s);
            res.inv[3*i+j] = q > 64'(32'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                             q < -64'sh80000000 ? 32'sh80000000 : q[31:0];
         end
         q = sat_sub(0, mul_div(u, ONE, s));
         res.sh[i] = q > 64'(S48MX) ? S48MX : q < 64'(S48MN) ? S48MN : q[47:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_valid) begin
         if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            want = pending_inverses.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_inv[i] !== want.inv[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("inv_%0d%0d: expected %h, got %h",
                              i / 3, i % 3, want.inv[i], rsp_inv[i]);
               end
            for (int i = 0; i < 3; i++)
               if (rsp_sh[i] !== want.sh[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("inv_shift[%0d]: expected %h, got %h",
                              i, want.sh[i], rsp_sh[i]);
               end
         end
      end
   end

   // ---------------------------------------------------------------- driving
   // write one register through the APB port: setup, then access
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_ITER) model_iter = value[7:0];
      else model_thresh = value[15:0];
   endtask

   // hold start low until every expected result is back, then let the core settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] iter, input logic [15:0] thresh);
      drain();
      write_reg(ADDR_ITER, 32'(iter));
      write_reg(ADDR_THRESH, 32'(thresh));
   endtask

   // present a request, hold it until accepted and record its expected inverse
   task automatic send_request(input transform_type tf, input bit has_exp,
                               input inverse_type exp);
      req_rs <= tf.rs;
      req_sh <= tf.sh;
      start  <= 1'b1;
      do @(posedge clock); while (busy);
      pending_inverses.insert(pending_inverses.size(),
                              has_exp ? exp : invert_transform(tf));
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic transform_type make_tf(input logic signed [31:0] a0, a1, a2,
                                             a3, a4, a5, a6, a7, a8,
                                             input logic signed [47:0] x, y, z);
      transform_type tf;
      tf.rs = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
      tf.sh = '{x, y, z};
      return tf;
   endfunction

   function automatic logic signed [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // mostly a scaled signed permutation with a little noise, sometimes noise only
   function automatic transform_type rand_tf();
      transform_type tf;
      int perm [3];
      int pick, i, j, scale;
      pick = $urandom_range(0, 5);
      perm = '{pick % 3, (pick % 3 + 1 + pick / 3) % 3, 0};
      perm[2] = 3 - perm[0] - perm[1];
      for (i = 0; i < 3; i++) begin
         scale = $urandom_range(32'h8000, 32'h40000);
         for (j = 0; j < 3; j++) begin
            tf.rs[3*i+j] = $signed($urandom_range(0, 32'h1000)) - 32'sh800;
            if (j == perm[i])
               tf.rs[3*i+j] += ($urandom_range(0, 1) ? scale : -scale);
         end
         tf.sh[i] = $urandom_range(0, 3) == 0 ? rand48() :
                    48'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh800000);
      end
      case ($urandom_range(0, 9))
         0: for (i = 0; i < 9; i++) tf.rs[i] = $urandom;
         1: for (i = 0; i < 9; i++) tf.rs[i] = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         default: ;
      endcase
      return tf;
   endfunction

   function automatic dir_row_type cfg_row(input logic [7:0] iter, input logic [15:0] thresh);
      dir_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.iter = iter;
      row.thresh = thresh;
      return row;
   endfunction

   function automatic dir_row_type req_row(input transform_type tf);
      dir_row_type row;
      row = '{default: '0};
      row.req = tf;
      return row;
   endfunction

   initial begin
      transform_type tf;
      inverse_type   none;
      int            idle_left;
      int            n;

      reset   = 1'b1;
      start   = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_rs  = '{default: '0};
      req_sh  = '{default: '0};
      none    = '{default: '{default: '0}};
      mismatches   = 0;
      model_iter   = trspd_pkg::MAX_ITER_RST;
      model_thresh = trspd_pkg::THRESH_RST;

      // identity with a shift: inverse is the identity with the shift negated
      dir_table[0] = req_row(make_tf(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                     48'sh10000, -48'sh20000, 48'sh30000));
      dir_table[0].has_exp = 1'b1;
      dir_table[0].exp.inv = '{UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT};
      dir_table[0].exp.sh  = '{-48'sh10000, 48'sh20000, -48'sh30000};
      // all-zero matrix: zero determinant and zero scales give zero over zero
      dir_table[1] = req_row(make_tf(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_table[1].has_exp = 1'b1;
      dir_table[1].exp = none;
      dir_table[2] = req_row(make_tf(UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                     S48MX, S48MN, -48'sd1));
      dir_table[3] = req_row(make_tf(0, -UNIT, 0, UNIT, 0, 0, 0, 0, UNIT,
                                     48'sh12345, 48'sh54321, -48'sh777));
      dir_table[4] = req_row(make_tf(2*UNIT, 0, 0, 0, 2*UNIT, 0, 0, 0, 2*UNIT,
                                     48'sh40000, 48'sh0, -48'sh40000));
      // longest limit with the loosest threshold
      dir_table[5] = cfg_row(8'd255, 16'hFFFF);
      dir_table[6] = req_row(make_tf(-UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                     48'sh1, 48'sh2, 48'sh3));
      dir_table[7] = req_row(make_tf(2*UNIT, 0, 0, 0, 3*UNIT, 0, 0, 0, 4*UNIT,
                                     48'sh90000, -48'sh90000, 48'sh1));
      dir_table[8] = req_row(make_tf(0, 0, 3*UNIT, UNIT/2, 0, 0, 0, -UNIT, 0,
                                     S48MN, S48MX, 0));
      // a zero limit still runs one step; exact convergence only
      dir_table[9] = cfg_row(8'd0, 16'h0000);
      dir_table[10] = req_row(make_tf(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      S48MX, S48MX, S48MX));
      dir_table[11] = req_row(make_tf(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      S48MN, S48MN, S48MN));
      dir_table[12] = req_row(make_tf(32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000, 0,
                                      0, 0, 32'sh7FFFFFFF, -48'sd1, 48'sd1, 0));
      dir_table[13] = req_row(make_tf(UNIT, 2*UNIT, 3*UNIT, 2*UNIT, 4*UNIT, 6*UNIT,
                                      -UNIT, -2*UNIT, -3*UNIT, 48'sh10000, 0, 0));
      dir_table[14] = req_row(make_tf(1, 0, 0, 0, 1, 0, 0, 0, 1,
                                      48'sh10000, 48'sh10000, 48'sh10000));
      dir_table[15] = req_row(make_tf(-1, -1, -1, -1, -1, -1, -1, -1, -1,
                                      -48'sd1, -48'sd1, -48'sd1));
      dir_table[16] = cfg_row(8'd1, 16'd7);
      dir_table[17] = req_row(make_tf(UNIT, UNIT/8, 0, -UNIT/8, UNIT, UNIT/16,
                                      0, 0, UNIT, 48'sh50000, 48'sh60000, 48'sh70000));
      dir_table[18] = cfg_row(8'd4, 16'h8000);
      dir_table[19] = req_row(make_tf(3*UNIT, UNIT, 0, -UNIT, 2*UNIT, UNIT/4,
                                      UNIT/2, 0, -UNIT, -48'sh100, 48'sh200, -48'sh300));
      dir_table[20] = req_row(make_tf(0, 0, 0, 0, UNIT, 0, 0, 0, UNIT,
                                      48'sh10000, 48'sh10000, 48'sh10000));
      dir_table[21] = req_row(make_tf(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
                                      32'shF0F0F0F0, 32'sh33333333, 32'shCCCCCCCC,
                                      32'sh00FF00FF, 32'shFF00FF00, 32'sh12345678,
                                      48'sh555555555555, 48'shAAAAAAAAAAAA,
                                      48'sh0F0F0F0F0F0F));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: walk the table
      foreach (dir_table[i]) begin
         if (dir_table[i].is_cfg)
            configure(dir_table[i].iter, dir_table[i].thresh);
         else
            send_request(dir_table[i].req, dir_table[i].has_exp, dir_table[i].exp);
      end

      // random part: short iteration limits keep the run length sane
      n = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(8'd1, 16'd0);
            1: configure(8'd6, 16'hFFFF);
            default: configure(8'($urandom_range(1, 6)), 16'($urandom_range(0, 16'hFFFF)));
         endcase
         for (int k = 0; k < 50; k++) begin
            // random idle bursts, none in the closing stretch
            if (n < 260 && $urandom_range(0, 2) == 0) begin
               idle_left = $urandom_range(1, 11);
               start <= 1'b0;
               repeat (idle_left) @(posedge clock);
            end
            tf = rand_tf();
            send_request(tf, 1'b0, none);
            n++;
         end
      end

      // drop the request line and wait for the tail of results
      start <= 1'b0;
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_inverses.size() == 0)
         $display("trs_polar_decomposition_inverse_core test passed");
      else
         $display("trs_polar_decomposition_inverse_core test failed");
      $finish;
   end

endmodule
